/* src/uts_pkg.sv */
package uts_pkg;

   // request codes
   typedef enum logic [2:0] {
      ACT_NEW      = 3'd0,
      ACT_BACKDATE = 3'd1,
      ACT_CATCH_UP = 3'd2,
      ACT_EPSILON  = 3'd3,
      ACT_AGE      = 3'd4,
      ACT_LOWEST   = 3'd5,
      ACT_HIGHEST  = 3'd6,
      ACT_NONE     = 3'd7
   } action_type;

   localparam int US_W   = 48;
   localparam int CNT_W  = 16;
   localparam int NODE_W = 48;

   localparam logic [15:0] STAMP_TAG = 16'hbeec;
   localparam logic [41:0] US_PER_MS = 42'd1000;

   // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for any 32-bit unsigned x
   localparam logic [28:0] MS_RECIP = 29'h10624dd3;
   localparam int          MS_SHIFT = 38;

endpackage

/* src/unique_timestamp_generator_top.sv */
// Unique timestamp generator: issues unique, monotonic 128-bit timestamps. The high word is the
// tag 0xbeec over a 48-bit microsecond value (req_now_us plus a kept clock offset), the low word
// a 16-bit same-microsecond counter over the 48-bit node id written through csr_write_data.
// Besides new stamps it backdates by milliseconds, catches up to a remote stamp, adds epsilon to
// a given stamp, reports the age of a given stamp and gives the lowest and highest stamps.
// The block is a three-register pipeline: input register, a single pass that updates the
// offset, counter and last-microsecond state and forms the stamp, then a result register where
// the backdate subtraction and the divide-by-1000 for the age finish. It takes one transaction
// every cycle unless rsp_ready held low stalls the pipeline; a request passes the input, middle
// and result registers before it shows on rsp_valid. The state update loop in the middle stage
// sets that rate. Write node_id only while no transaction is in flight.
module unique_timestamp_generator_top (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [47:0]        csr_write_data,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [63:0]        req_now_us,
   input  logic signed [31:0] req_back_ms,
   input  logic [63:0]        req_given_high,
   input  logic [63:0]        req_given_low,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_stamp_high,
   output logic [63:0]        rsp_stamp_low,
   output logic signed [31:0] rsp_age_us,
   output logic signed [31:0] rsp_age_ms,
   output logic               rsp_counter_wrapped
);

   localparam int US_W   = uts_pkg::US_W;
   localparam int CNT_W  = uts_pkg::CNT_W;
   localparam int NODE_W = uts_pkg::NODE_W;

   // pipeline flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic en1, en2, en3, adv2;

   // node id register
   logic [NODE_W-1:0] node_id_ff;

   // kept state
   logic [63:0]       offset_ff,  offset_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic [US_W-1:0]   last_us_ff, last_us_in;

   // stage 1: accepted request, with the parts that need no state worked out already
   uts_pkg::action_type s1_action_ff;
   logic [63:0]         s1_now_ff;
   logic [63:0]         s1_given_high_ff;
   logic [CNT_W-1:0]    s1_given_cnt_ff;
   logic signed [41:0]  s1_back_us_ff, s1_back_us_in;
   logic signed [48:0]  s1_delta_ff,   s1_delta_in;

   // stage 2: stamp before backdating, age before the divide
   logic [63:0]        s2_stamp_high_ff, s2_stamp_high_in;
   logic [63:0]        s2_stamp_low_ff,  s2_stamp_low_in;
   logic signed [41:0] s2_back_us_ff;
   logic [31:0]        s2_age_us_ff,  s2_age_us_in;
   logic [31:0]        s2_age_abs_ff, s2_age_abs_in;
   logic               s2_age_neg_ff, s2_age_neg_in;
   logic               s2_wrapped_ff, s2_wrapped_in;

   // stage 3: result register
   logic [63:0]        s3_stamp_high_ff, s3_stamp_high_in;
   logic [63:0]        s3_stamp_low_ff;
   logic [31:0]        s3_age_us_ff;
   logic [31:0]        s3_age_ms_ff, s3_age_ms_in;
   logic               s3_wrapped_ff;

   // middle stage helpers
   logic [US_W-1:0]   sum_us, us_inc, us_out, given_us_inc;
   logic [CNT_W:0]    count_inc, given_cnt_inc;
   logic [63:0]       delta_ext;
   logic              catch_ok;
   logic [31:0]       age_diff;

   // divider helpers
   logic [60:0]       ms_prod;
   logic [22:0]       ms_quot;

   // a stage loads when it is empty or its content moves on
   assign en3       = !s3_valid_ff || rsp_ready;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign adv2      = s1_valid_ff && en2;
   assign req_ready = en1;

   // ---------------------------------------------------------------- stage 1
   // backdate in microseconds and the catch-up delta depend only on the request
   assign s1_back_us_in = (uts_pkg::action_type'(req_action) == uts_pkg::ACT_BACKDATE)
                          ? 42'(req_back_ms) * $signed(uts_pkg::US_PER_MS) : 42'sd0;
   assign s1_delta_in   = $signed({1'b0, req_given_high[US_W-1:0]})
                          - $signed({1'b0, req_now_us[US_W-1:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
      if (en1 && req_valid) begin
         s1_action_ff     <= uts_pkg::action_type'(req_action);
         s1_now_ff        <= req_now_us;
         s1_given_high_ff <= req_given_high;
         s1_given_cnt_ff  <= req_given_low[63:64-CNT_W];
         s1_back_us_ff    <= s1_back_us_in;
         s1_delta_ff      <= s1_delta_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   assign sum_us        = s1_now_ff[US_W-1:0] + offset_ff[US_W-1:0];
   assign us_inc        = sum_us + 1'b1;
   assign count_inc     = {1'b0, count_ff} + 1'b1;
   assign given_cnt_inc = {1'b0, s1_given_cnt_ff} + 1'b1;
   assign given_us_inc  = s1_given_high_ff[US_W-1:0] + 1'b1;
   assign delta_ext     = 64'(s1_delta_ff);
   assign catch_ok      = $signed(delta_ext) >= $signed(offset_ff);
   // only the low 32 bits of the age survive
   assign age_diff      = s1_now_ff[31:0] + offset_ff[31:0] - s1_given_high_ff[31:0];

   always_comb begin
      offset_in        = offset_ff;
      count_in         = count_ff;
      last_us_in       = last_us_ff;
      us_out           = sum_us;
      s2_stamp_high_in = 64'd0;
      s2_stamp_low_in  = 64'd0;
      s2_age_us_in     = 32'd0;
      s2_wrapped_in    = 1'b0;
      case (s1_action_ff)
         uts_pkg::ACT_NEW, uts_pkg::ACT_BACKDATE: begin
            if (sum_us != last_us_ff) begin
               count_in   = '0;
               last_us_in = sum_us;
            end else if (count_inc[CNT_W]) begin
               // counter rolled over: bump the microseconds
               s2_wrapped_in = 1'b1;
               us_out        = us_inc;
               count_in      = '0;
               last_us_in    = '0;
            end else begin
               count_in = count_inc[CNT_W-1:0];
            end
            s2_stamp_high_in = {uts_pkg::STAMP_TAG, us_out};
            s2_stamp_low_in  = {count_in, node_id_ff};
         end
         uts_pkg::ACT_CATCH_UP: begin
            if (catch_ok) begin
               if (given_cnt_inc[CNT_W]) begin
                  s2_wrapped_in = 1'b1;
                  offset_in     = delta_ext + 64'd1;
                  count_in      = '0;
                  last_us_in    = given_us_inc;
               end else begin
                  offset_in  = delta_ext;
                  count_in   = given_cnt_inc[CNT_W-1:0];
                  last_us_in = s1_given_high_ff[US_W-1:0];
               end
            end
         end
         uts_pkg::ACT_EPSILON: begin
            if (given_cnt_inc[CNT_W]) begin
               s2_wrapped_in    = 1'b1;
               s2_stamp_high_in = s1_given_high_ff + 64'd1;
               s2_stamp_low_in  = {{CNT_W{1'b0}}, node_id_ff};
            end else begin
               s2_stamp_high_in = s1_given_high_ff;
               s2_stamp_low_in  = {given_cnt_inc[CNT_W-1:0], node_id_ff};
            end
         end
         uts_pkg::ACT_AGE: begin
            s2_age_us_in = age_diff;
         end
         uts_pkg::ACT_LOWEST: begin
            s2_stamp_high_in = {uts_pkg::STAMP_TAG, {US_W{1'b0}}};
            s2_stamp_low_in  = {{CNT_W{1'b0}}, node_id_ff};
         end
         uts_pkg::ACT_HIGHEST: begin
            s2_stamp_high_in = {uts_pkg::STAMP_TAG, {US_W{1'b1}}};
            s2_stamp_low_in  = {{CNT_W{1'b1}}, node_id_ff};
         end
         default: begin
         end
      endcase
   end

   // sign and magnitude for the divide
   assign s2_age_neg_in = s2_age_us_in[31];
   assign s2_age_abs_in = s2_age_neg_in ? (32'd0 - s2_age_us_in) : s2_age_us_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         offset_ff   <= '0;
         count_ff    <= '0;
         last_us_ff  <= '0;
         node_id_ff  <= '0;
      end else begin
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv2) begin
            offset_ff  <= offset_in;
            count_ff   <= count_in;
            last_us_ff <= last_us_in;
         end
         if (csr_write_enable) begin
            node_id_ff <= csr_write_data;
         end
      end
      if (adv2) begin
         s2_stamp_high_ff <= s2_stamp_high_in;
         s2_stamp_low_ff  <= s2_stamp_low_in;
         s2_back_us_ff    <= s1_back_us_ff;
         s2_age_us_ff     <= s2_age_us_in;
         s2_age_abs_ff    <= s2_age_abs_in;
         s2_age_neg_ff    <= s2_age_neg_in;
         s2_wrapped_ff    <= s2_wrapped_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // backdate applies to the whole high word, tag included
   assign s3_stamp_high_in = s2_stamp_high_ff - 64'(s2_back_us_ff);

   // divide by 1000 through the reciprocal, truncating toward zero
   assign ms_prod      = 61'(s2_age_abs_ff) * 61'(uts_pkg::MS_RECIP);
   assign ms_quot      = ms_prod[60:uts_pkg::MS_SHIFT];
   assign s3_age_ms_in = s2_age_neg_ff ? (32'd0 - 32'(ms_quot)) : 32'(ms_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en3 && s2_valid_ff) begin
         s3_stamp_high_ff <= s3_stamp_high_in;
         s3_stamp_low_ff  <= s2_stamp_low_ff;
         s3_age_us_ff     <= s2_age_us_ff;
         s3_age_ms_ff     <= s3_age_ms_in;
         s3_wrapped_ff    <= s2_wrapped_ff;
      end
   end

   assign rsp_valid           = s3_valid_ff;
   assign rsp_stamp_high      = s3_stamp_high_ff;
   assign rsp_stamp_low       = s3_stamp_low_ff;
   assign rsp_age_us          = $signed(s3_age_us_ff);
   assign rsp_age_ms          = $signed(s3_age_ms_ff);
   assign rsp_counter_wrapped = s3_wrapped_ff;

endmodule

/* src/uts_checker.sv */
module uts_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [63:0]        rsp_stamp_high,
   input logic [63:0]        rsp_stamp_low,
   input logic signed [31:0] rsp_age_us,
   input logic signed [31:0] rsp_age_ms,
   input logic               rsp_counter_wrapped
);

   // a stalled response stays valid and holds its stamp and age_ms
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stamp_high)
         && $stable(rsp_stamp_low) && $stable(rsp_age_ms))
      else $error("response changed while stalled");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an age transaction carries no stamp
   a_age_no_stamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_age_us != 32'sd0) |-> (rsp_stamp_high == 64'd0)
         && (rsp_stamp_low == 64'd0))
      else $error("age result with a stamp");

   // a wrap always leaves the counter at zero and no age
   a_wrap_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_counter_wrapped |-> (rsp_stamp_low[63:48] == 16'd0)
         && (rsp_age_us == 32'sd0))
      else $error("wrap with nonzero counter or age");

   // milliseconds are never negative when microseconds are not
   a_age_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_age_us[31] |-> !rsp_age_ms[31])
      else $error("age_ms sign mismatch");

endmodule

bind unique_timestamp_generator_top uts_checker u_uts_checker (.*);
